/* rtl/core/pcxrle_pkg.sv */
package pcxrle_pkg;

  // Width of a frame-buffer address; addresses wrap modulo 2^ADDR_BITS.
  localparam int ADDR_BITS = 20;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;

  // A byte with both top bits set is a run header; its low six bits are the count.
  localparam logic [7:0] RUN_MARK = 8'hC0;
  localparam logic [7:0] RUN_MASK = 8'h3F;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } pcx_in_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] pixel_address;
    logic [7:0]           pixel_value;
    logic                 last_of_run;
    logic                 image_done;
  } pcx_out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_STRIDE  = 3'd0,
    CFG_FRAME_ROWS  = 3'd1,
    CFG_START_ROW   = 3'd2,
    CFG_LAST_COLUMN = 3'd3,
    CFG_LAST_ROW    = 3'd4
  } cfg_reg_t;

  // Sequencer step addresses and jump conditions.
  typedef enum logic {
    STEP_FETCH = 1'b0,
    STEP_EMIT  = 1'b1
  } step_t;

  typedef enum logic {
    COND_PIXEL_ITEM = 1'b0,
    COND_RUN_END    = 1'b1
  } cond_t;

  // One control word: which datapath actions are enabled in this step, and
  // where to jump when the step's condition is true. Otherwise the step repeats.
  typedef struct packed {
    logic  take_in;
    logic  emit;
    cond_t cond;
    step_t target;
  } ctl_word_t;

  // Microcode store. The fetch step accepts a byte and decodes it; the emit
  // step writes one pixel per transfer until the pending count runs out.
  function automatic ctl_word_t ucode_rom(step_t step);
    ctl_word_t word;
    unique case (step)
      STEP_FETCH: word = '{take_in: 1'b1, emit: 1'b0, cond: COND_PIXEL_ITEM,
                           target: STEP_EMIT};
      STEP_EMIT:  word = '{take_in: 1'b0, emit: 1'b1, cond: COND_RUN_END,
                           target: STEP_FETCH};
      default:    word = '{take_in: 1'b1, emit: 1'b0, cond: COND_PIXEL_ITEM,
                           target: STEP_EMIT};
    endcase
    return word;
  endfunction

endpackage

/* rtl/core/pcx_rle_decoder_unit.sv */
// PCX run-length decoder. Each input transfer carries one body byte (or, with
// cmd set, a start-of-image command that clears the position). A literal byte
// produces one pixel write; a run header produces none and arms the decoder,
// and the following byte is then written as many times as the header's count
// (zero to 63). Write addresses are (start_row + row) * row_stride + column,
// modulo 2^20. After each literal or run the column wraps past the clamped
// last column and the row advances; once the row passes the clamped last row
// the final write (if any) carries image_done and further data bytes are
// dropped until the next start command. Control is a two-step microprogram:
// a start command, a run header or an ignored byte needs only the fetch step;
// a literal or a run value byte is fetched, then written by the emit step
// once or as many times as the run's count (a zero-length run still passes
// through the emit step). The emit step writes one pixel per cycle while
// out_ready is high and holds while it is low. Input and output are
// never ready or valid in the same cycle. Configuration registers are written
// through the cfg port (always ready) and must only change while idle.
module pcx_rle_decoder_unit
  import pcxrle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  pcx_in_t               in_data,

  output logic                  out_valid,
  input  logic                  out_ready,
  output pcx_out_t              out_data,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [10:0] row_stride_r;
  logic [10:0] frame_rows_r;
  logic [9:0]  start_row_r;
  logic [9:0]  last_column_r;
  logic [9:0]  last_row_r;

  // Sequencer and decoder state.
  step_t       pc_r, pc_nxt;
  logic        await_r, await_nxt;
  logic [5:0]  run_count_r, run_count_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [10:0] column_r, column_nxt;
  logic [10:0] row_off_r, row_off_nxt;
  logic        finished_r, finished_nxt;

  // Item payload, loaded when a pixel-producing byte is fetched.
  logic [ADDR_BITS-1:0] base_r;
  logic [7:0]           value_r;

  ctl_word_t   ctl;
  logic        in_fire, out_fire, cfg_fire;
  logic        is_header, pixel_item, run_end, jump;
  logic        last_write;
  logic [10:0] col_inc, col_end, mx, my, row_next;
  logic        wrap, done;
  logic [11:0] dest_row;
  logic [22:0] row_product;

  assign ctl       = ucode_rom(pc_r);
  assign in_ready  = ctl.take_in;
  assign cfg_ready = 1'b1;

  assign in_fire  = in_valid && in_ready;
  assign cfg_fire = cfg_valid && cfg_ready;

  // A data byte that is neither ignored nor a header starts the emit step.
  assign is_header  = (in_data.in_byte & RUN_MARK) == RUN_MARK;
  assign pixel_item = in_fire && !in_data.cmd && !finished_r && (await_r || !is_header);

  // Row base for the item; the multiplier output is registered before the add.
  assign dest_row    = 12'(start_row_r) + 12'(row_off_r);
  assign row_product = 23'(dest_row) * 23'(row_stride_r);

  // Clamped edges: an edge at or beyond the size is replaced by the size.
  assign mx = (11'(last_column_r) >= row_stride_r) ? row_stride_r : 11'(last_column_r);
  assign my = (11'(last_row_r) >= frame_rows_r) ? frame_rows_r : 11'(last_row_r);

  // End-of-item position: the column after the last write (or unchanged when
  // the run was empty), then the wrap and finish checks.
  assign col_inc    = column_r + 11'd1;
  assign col_end    = (cnt_r == '0) ? column_r : col_inc;
  assign wrap       = col_end > mx;
  assign row_next   = wrap ? (row_off_r + 11'd1) : row_off_r;
  assign done       = row_next > my;
  assign last_write = cnt_r == 6'd1;

  assign out_valid = ctl.emit && (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;

  assign out_data.pixel_address = base_r + ADDR_BITS'(column_r);
  assign out_data.pixel_value   = value_r;
  assign out_data.last_of_run   = last_write;
  assign out_data.image_done    = last_write && done;

  assign run_end = ctl.emit && ((cnt_r == '0) || (out_fire && last_write));

  always_comb begin
    unique case (ctl.cond)
      COND_PIXEL_ITEM: jump = pixel_item;
      COND_RUN_END:    jump = run_end;
      default:         jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt        = jump ? ctl.target : pc_r;
    await_nxt     = await_r;
    run_count_nxt = run_count_r;
    cnt_nxt       = cnt_r;
    column_nxt    = column_r;
    row_off_nxt   = row_off_r;
    finished_nxt  = finished_r;

    if (in_fire) begin
      if (in_data.cmd) begin
        await_nxt     = 1'b0;
        run_count_nxt = '0;
        column_nxt    = '0;
        row_off_nxt   = '0;
        finished_nxt  = 1'b0;
      end else if (!finished_r) begin
        if (!await_r && is_header) begin
          await_nxt     = 1'b1;
          run_count_nxt = 6'(in_data.in_byte & RUN_MASK);
        end else begin
          cnt_nxt       = await_r ? run_count_r : 6'd1;
          await_nxt     = 1'b0;
          run_count_nxt = '0;
        end
      end
    end

    if (out_fire) begin
      column_nxt = col_inc;
      cnt_nxt    = cnt_r - 6'd1;
    end

    // The end of a run applies the wrap and finish checks.
    if (run_end) begin
      column_nxt   = wrap ? '0 : col_end;
      row_off_nxt  = row_next;
      finished_nxt = done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= STEP_FETCH;
      await_r       <= 1'b0;
      run_count_r   <= '0;
      cnt_r         <= '0;
      column_r      <= '0;
      row_off_r     <= '0;
      finished_r    <= 1'b0;
      row_stride_r  <= 11'd352;
      frame_rows_r  <= 11'd744;
      start_row_r   <= 10'd0;
      last_column_r <= 10'd319;
      last_row_r    <= 10'd199;
    end else begin
      pc_r        <= pc_nxt;
      await_r     <= await_nxt;
      run_count_r <= run_count_nxt;
      cnt_r       <= cnt_nxt;
      column_r    <= column_nxt;
      row_off_r   <= row_off_nxt;
      finished_r  <= finished_nxt;
      if (cfg_fire) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_ROW_STRIDE:  row_stride_r  <= cfg_data;
          CFG_FRAME_ROWS:  frame_rows_r  <= cfg_data;
          CFG_START_ROW:   start_row_r   <= cfg_data[9:0];
          CFG_LAST_COLUMN: last_column_r <= cfg_data[9:0];
          CFG_LAST_ROW:    last_row_r    <= cfg_data[9:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_item) begin
      base_r  <= row_product[ADDR_BITS-1:0];
      value_r <= in_data.in_byte;
    end
  end

`ifndef SYNTHESIS
  // The sequencer never takes a byte while a write is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a pixel write is pending");

  // A finished image produces no writes.
  a_quiet_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !out_valid)
    else $error("pixel write after the image finished");

  // The last write of a run returns control to the fetch step.
  a_fetch_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_data.last_of_run) |=> in_ready)
    else $error("no fetch after the last write of a run");

  // A write that is not the last one is followed by another write.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_data.last_of_run) |=> out_valid)
    else $error("run ended before its count ran out");
`endif

endmodule

/* tb/pcx_rle_checker.sv */
`timescale 1ns / 1ps

// Watches the byte, pixel and register channels of the PCX decoder. It keeps
// its own decoder state, turns every accepted byte into the pixel writes the
// block should produce, and compares each pixel transfer with the oldest one.
module pcx_rle_checker
  import pcxrle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  input  logic                  in_ready,
  input  pcx_in_t               in_data,

  input  logic                  out_valid,
  input  logic                  out_ready,
  input  pcx_out_t              out_data,

  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  output int                    mismatches,
  output int                    writes_pending,
  output int                    writes_checked,
  output int                    images_completed,
  output int                    bytes_used,
  output logic                  image_closed
);

  pcx_out_t pixel_q[$];

  // Register copies.
  logic [10:0] stride_r;
  logic [10:0] frame_rows_r;
  logic [9:0]  first_row_r;
  logic [9:0]  edge_col_r;
  logic [9:0]  edge_row_r;

  // Decoder position.
  logic        run_armed;
  logic [5:0]  run_len;
  logic [10:0] col;
  logic [10:0] row_off;
  logic        img_over;

  int fail_cnt;
  int checked_cnt;
  int done_cnt;
  int used_cnt;

  // The edge register wins unless it lies at or beyond the size, in which case the
  // size itself is used. The comparison is signed, so a zero size clamps to 0.
  function automatic int edge_clamp(int edge_v, int size_v);
    return (edge_v > size_v - 1) ? size_v : edge_v;
  endfunction

  task automatic clear_position();
    run_armed = 1'b0;
    run_len   = '0;
    col       = '0;
    row_off   = '0;
    img_over  = 1'b0;
  endtask

  task automatic decode_byte(input pcx_in_t item);
    int          count;
    int          row;
    int          addr;
    logic [10:0] end_col;
    logic [10:0] next_row;
    logic        wrap;
    logic        closes;
    pcx_out_t    px;
    if (item.cmd) begin
      clear_position();
      used_cnt++;
      return;
    end
    if (img_over) return;
    used_cnt++;
    if (!run_armed && (item.in_byte & RUN_MARK) == RUN_MARK) begin
      run_armed = 1'b1;
      run_len   = item.in_byte[5:0] & RUN_MASK[5:0];
      return;
    end
    count     = run_armed ? int'(run_len) : 1;
    run_armed = 1'b0;
    run_len   = '0;

    // The wrap and finish decisions only depend on where the column ends up,
    // so they are settled before the writes are queued.
    end_col  = col + 11'(count);
    wrap     = int'(end_col) > edge_clamp(int'(edge_col_r), int'(stride_r));
    next_row = wrap ? row_off + 11'd1 : row_off;
    closes   = int'(next_row) > edge_clamp(int'(edge_row_r), int'(frame_rows_r));

    row = int'(first_row_r) + int'(row_off);
    for (int k = 0; k < count; k++) begin
      addr             = row * int'(stride_r) + int'(col);
      px.pixel_address = addr[ADDR_BITS-1:0];
      px.pixel_value   = item.in_byte;
      px.last_of_run   = (k == count - 1);
      px.image_done    = closes && (k == count - 1);
      pixel_q.push_back(px);
      col = col + 11'd1;
    end

    if (wrap) col = '0;
    row_off  = next_row;
    img_over = closes;
  endtask

  task automatic compare_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    pcx_out_t exp_px;
    if (!rst_n) begin
      stride_r     = 11'd352;
      frame_rows_r = 11'd744;
      first_row_r  = 10'd0;
      edge_col_r   = 10'd319;
      edge_row_r   = 10'd199;
      clear_position();
      pixel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ROW_STRIDE:  stride_r     = cfg_data[10:0];
          CFG_FRAME_ROWS:  frame_rows_r = cfg_data[10:0];
          CFG_START_ROW:   first_row_r  = cfg_data[9:0];
          CFG_LAST_COLUMN: edge_col_r   = cfg_data[9:0];
          CFG_LAST_ROW:    edge_row_r   = cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) decode_byte(in_data);
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel write with none expected: address 0x%0h, value 0x%0h",
                 out_data.pixel_address, out_data.pixel_value);
          fail_cnt++;
        end else begin
          exp_px = pixel_q.pop_front();
          compare_field("pixel_address", int'(exp_px.pixel_address),
                        int'(out_data.pixel_address));
          compare_field("pixel_value", int'(exp_px.pixel_value),
                        int'(out_data.pixel_value));
          compare_field("last_of_run", int'(exp_px.last_of_run),
                        int'(out_data.last_of_run));
          compare_field("image_done", int'(exp_px.image_done),
                        int'(out_data.image_done));
          checked_cnt++;
          if (exp_px.image_done) done_cnt++;
        end
      end
    end
    mismatches       <= fail_cnt;
    writes_pending   <= pixel_q.size();
    writes_checked   <= checked_cnt;
    images_completed <= done_cnt;
    bytes_used       <= used_cnt;
    image_closed     <= img_over;
  end

  initial begin
    fail_cnt    = 0;
    checked_cnt = 0;
    done_cnt    = 0;
    used_cnt    = 0;
  end

endmodule

/* tb/tb_pcx_rle_decoder_unit.sv */
`timescale 1ns / 1ps

// Top of the PCX decoder testbench. It makes the byte stream and the register
// writes, drives a stalling pixel receiver, and gives the verdict; all
// prediction and comparison happens in the checker instantiated beside the
// block.
module tb_pcx_rle_decoder_unit;
  import pcxrle_pkg::*;

  // The longest quiet stretch of a correct run is the long receiver hold
  // (HOLD_CYCLES) plus a register pause, so this leaves ample margin.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  // Cycles let pass after the last expected pixel before registers change,
  // covering a zero-length run that still passes through the block's emit step.
  localparam int SETTLE_CYCLES = 20;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  pcx_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  pcx_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   mismatches;
  int   writes_pending;
  int   writes_checked;
  int   images_completed;
  int   bytes_used;
  logic image_closed;

  int burst_left;
  int items_sent;
  int settings_used;
  int hold_req;
  int quiet_cycles;

  pcx_rle_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcx_rle_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .writes_pending   (writes_pending),
    .writes_checked   (writes_checked),
    .images_completed (images_completed),
    .bytes_used       (bytes_used),
    .image_closed     (image_closed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Pixel receiver. It normally switches between four stall patterns, one of
  // which never stalls. When the stimulus asks for it, it refuses every
  // transfer for a long stretch that it counts itself, so the block fills up
  // and has to hold off the byte channel.
  initial begin
    int hold_seen;
    int hold_left;
    int mode;
    int mode_left;
    int tick;
    hold_seen = 0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (tick % 4 != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // One byte transfer. The sender works in bursts: at the start of each burst
  // it may drop valid for a random gap, and within a burst valid stays high
  // from one transfer to the next with only the payload changing.
  task automatic send_item(input logic is_cmd, input logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{cmd: is_cmd, in_byte: b};
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_run(input int count, input logic [7:0] value);
    send_item(1'b0, RUN_MARK | 8'(count));
    send_item(1'b0, value);
  endtask

  // Stops offering bytes and waits until every predicted pixel has arrived,
  // then lets the block run dry in case the last byte produced no pixel.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (writes_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Registers only change while the block is idle, so every update starts
  // by draining it.
  task automatic set_regs(input int stride, input int rows, input int first,
                          input int edge_c, input int edge_r);
    settle();
    write_reg(CFG_ROW_STRIDE, stride);
    write_reg(CFG_FRAME_ROWS, rows);
    write_reg(CFG_START_ROW, first);
    write_reg(CFG_LAST_COLUMN, edge_c);
    write_reg(CFG_LAST_ROW, edge_r);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Small random images so that rows advance and images finish often, with
  // an occasional out-of-range or extreme register value.
  task automatic random_regs();
    int stride;
    int rows;
    int edge_c;
    int edge_r;
    case ($urandom_range(0, 9))
      0: stride = 0;
      1: stride = 2047;
      2: stride = 1024;
      3: stride = 1;
      default: stride = $urandom_range(2, 1024);
    endcase
    case ($urandom_range(0, 9))
      0: rows = 0;
      1: rows = 2047;
      2, 3, 4: rows = $urandom_range(1, 8);
      default: rows = $urandom_range(1, 1024);
    endcase
    edge_c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
    edge_r = ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(0, 6);
    set_regs(stride, rows, $urandom_range(0, 1023), edge_c, edge_r);
  endtask

  // Mostly well-formed image bodies (literals and header/value pairs with
  // random contents), mixed with start commands, raw noise bytes that can
  // leave a header without its value, and restarts once an image is done.
  task automatic random_phase(input int n, input bit with_hold, input bit mid_pause);
    int goal;
    int pick;
    int len;
    if ($urandom_range(0, 1)) send_item(1'b1, 8'($urandom_range(0, 255)));
    if (with_hold) begin
      hold_req++;
      repeat (3) send_run(63, 8'($urandom_range(0, 255)));
    end
    goal = bytes_used + n;
    while (bytes_used < goal) begin
      if (mid_pause && bytes_used >= goal - n / 2) begin
        mid_pause = 1'b0;
        settle();
      end
      pick = $urandom_range(0, 99);
      if (image_closed && $urandom_range(0, 3) != 0) begin
        send_item(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 5) begin
        send_item(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 12) begin
        send_item(1'b0, 8'($urandom_range(0, 255)));
      end else if (pick < 55) begin
        send_item(1'b0, 8'($urandom_range(0, 191)));
      end else begin
        case ($urandom_range(0, 9))
          0: len = 0;
          1: len = 63;
          default: len = $urandom_range(1, 8);
        endcase
        send_run(len, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Watchdog: any transfer on any channel counts as progress.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_ROW_STRIDE;
    cfg_data      = '0;
    burst_left    = 0;
    items_sent    = 0;
    settings_used = 1;
    hold_req      = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset register values: literals at the byte extremes, an empty run, a
    // full 63-pixel run, a run whose value looks like a header, and a start
    // command that drops a pending run.
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hBF);
    send_run(0, 8'h55);
    send_run(63, 8'hFF);
    send_run(1, 8'hC3);
    send_item(1'b0, 8'hC5);
    send_item(1'b1, 8'h00);

    // Largest pitch and start row, so addresses wrap past the 20-bit range.
    set_regs(2047, 2047, 1023, 1023, 1023);
    send_item(1'b1, 8'($urandom_range(0, 255)));
    send_run(63, 8'hAB);
    send_item(1'b0, 8'h7F);

    // Shrinking the image under a column already past the edge: the empty
    // run then finishes the image without any pixel. Bytes that follow are
    // dropped until a start command, after which one literal fills the image.
    set_regs(1, 1, 0, 0, 0);
    send_run(0, 8'h00);
    send_item(1'b0, 8'h3F);
    send_item(1'b1, 8'h5A);
    send_item(1'b0, 8'h12);
    send_item(1'b0, 8'h34);

    // Zero pitch and zero frame height: addresses depend on the column only.
    set_regs(0, 0, $urandom_range(0, 1023), 1023, 1023);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h80);

    // Random part: the first phase also holds the receiver off for a long
    // stretch, the third pauses mid-way until all pixels have drained.
    for (int p = 0; p < 4; p++) begin
      random_regs();
      random_phase(20, p == 0, p == 2);
    end

    settle();
    $display("Sent %0d byte transfers under %0d register settings; checked %0d pixel writes",
             items_sent, settings_used, writes_checked);
    $display("and saw %0d images completed.", images_completed);
    if (mismatches == 0 && writes_pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
